>>> rtl/core/sida_pkg.sv
package sida_pkg;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  // decimal positions of a 32-bit magnitude: 10^9 down to 10^0
  localparam int         NUM_POW = 10;
  localparam logic [3:0] POW_TOP = 4'd9;
  localparam int         MULT_W  = 34;  // holds 9 * 10^9

  typedef struct packed {
    logic load;
    logic emit_sign;
    logic step;
  } sida_cmd_t;

  typedef struct packed {
    logic in_neg;
    logic out_free;
    logic pow_last;
  } sida_status_t;

  // d * 10^k for every position k and digit d
  typedef logic [NUM_POW-1:0][9:0][MULT_W-1:0] pow_tab_t;

  function automatic pow_tab_t build_pow_tab();
    pow_tab_t          t;
    logic [MULT_W-1:0] p;
    t = '0;
    p = MULT_W'(1);
    for (int k = 0; k < NUM_POW; k++) begin
      for (int d = 0; d < 10; d++) begin
        t[k][d] = MULT_W'(p * MULT_W'(d));
      end
      p = MULT_W'(p * MULT_W'(10));
    end
    return t;
  endfunction

  localparam pow_tab_t POW_TAB = build_pow_tab();

endpackage

>>> rtl/core/signed_int_to_decimal_ascii.sv
// After accept, a '-' goes out first if the value is negative; the first digit
//   follows once the leading-zero positions are walked. No new item is taken
//   until the current one's last digit step. The digit loop visits the ten powers
//   of ten, one per cycle unless the output stalls, through one trial-subtract bank.
// Reset (rst, synchronous): controller to idle, output register emptied.
module signed_int_to_decimal_ascii import sida_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         character,
  output logic               last
);

  // controller <-> datapath
  sida_cmd_t    cmd;
  sida_status_t status;

  // Sequencer: idle -> optional sign -> ten digit steps, each step waiting
  // on a free output register so no character is ever dropped.
  sida_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Magnitude register, power index and the output register. Each digit is
  // found by subtracting 1..9 times the current power of ten in parallel,
  // so the most negative value needs no special handling.
  sida_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .value     (value),
    .cmd       (cmd),
    .status    (status),
    .character (character),
    .last      (last),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // block goes busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready held after accept");

  // a sign never closes a run
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (character == CHAR_MINUS) |-> !last)
    else $error("'-' flagged last");

  // only '-' or a decimal digit leaves the block
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == CHAR_MINUS) ||
                  (character >= CHAR_ZERO && character <= CHAR_NINE))
    else $error("character out of range");

endmodule

>>> rtl/core/sida_dp.sv
module sida_dp import sida_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] value,
  input  sida_cmd_t          cmd,
  output sida_status_t       status,
  output logic [7:0]         character,
  output logic               last,
  output logic               out_valid,
  input  logic               out_ready
);

  logic [31:0] mag;
  logic [3:0]  pow_idx;
  logic        started;

  logic [MULT_W:0] diff [NUM_POW];
  logic [3:0]      digit;
  logic [31:0]     rem;
  logic            emit_digit;

  // trial subtract of every multiple of the current power; highest fit is the digit
  always_comb begin
    diff[0] = {3'b000, mag};
    for (int d = 1; d < 10; d++) begin
      diff[d] = {3'b000, mag} - {1'b0, POW_TAB[pow_idx][d]};
    end
    digit = '0;
    for (int d = 1; d < 10; d++) begin
      if (!diff[d][MULT_W]) digit = 4'(d);
    end
    rem = diff[digit][31:0];
  end

  // leading zeros are dropped, but the units digit always goes out
  assign emit_digit = cmd.step && (digit != '0 || started || pow_idx == '0);

  assign status.in_neg   = value[31];
  assign status.out_free = !out_valid || out_ready;
  assign status.pow_last = (pow_idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
      pow_idx   <= POW_TOP;
    end else begin
      // a new character fills the register; otherwise it empties on accept
      out_valid <= cmd.emit_sign || emit_digit || (out_valid && !out_ready);
      if (cmd.load) begin
        started <= 1'b0;
        pow_idx <= POW_TOP;
      end else if (cmd.step) begin
        started <= started || (digit != '0);
        pow_idx <= pow_idx - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= value[31] ? (32'd0 - $unsigned(value)) : $unsigned(value);
    end else if (cmd.step) begin
      mag <= rem;
    end
    if (cmd.emit_sign) begin
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else if (emit_digit) begin
      character <= CHAR_ZERO + {4'b0000, digit};
      last      <= (pow_idx == '0);
    end
  end

endmodule

>>> rtl/core/sida_ctrl.sv
module sida_ctrl import sida_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  sida_status_t status,
  output sida_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SIGN  = 3'b010,
    S_DIGIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = status.in_neg ? S_SIGN : S_DIGIT;
        end
      end
      S_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_next    = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (status.out_free) begin
          cmd.step = 1'b1;
          if (status.pow_last) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> tb/decimal_text_checker.sv
`timescale 1ns / 100ps

module decimal_text_checker import sida_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  character,
  input  logic        last,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [7:0] ch;
    logic       lst;
  } text_char_t;

  text_char_t text_q[$];

  // queue the decimal text of one number, sign first, top digit first
  function automatic void queue_decimal_text(logic [31:0] raw);
    logic [3:0]  digits [10];
    logic [31:0] mag;
    int          n;
    text_char_t  c;
    mag = raw[31] ? (32'd0 - raw) : raw;
    n = 0;
    do begin
      digits[n] = 4'(mag % 32'd10);
      mag = mag / 32'd10;
      n++;
    end while (mag != 0 && n < 10);
    if (raw[31]) begin
      c.ch  = CHAR_MINUS;
      c.lst = 1'b0;
      text_q.push_back(c);
    end
    for (int i = n - 1; i >= 0; i--) begin
      c.ch  = CHAR_ZERO + 8'(digits[i]);
      c.lst = (i == 0);
      text_q.push_back(c);
    end
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst) begin
      if (in_valid && in_ready) queue_decimal_text(value);
      if (out_valid && out_ready) begin
        if (text_q.size() == 0) begin
          $error("unexpected character %0d (last %0d)", character, last);
          errors <= errors + 1;
        end else begin
          exp_c = text_q.pop_front();
          if (character !== exp_c.ch || last !== exp_c.lst) begin
            if (character !== exp_c.ch)
              $error("character: expected %0d, got %0d", exp_c.ch, character);
            if (last !== exp_c.lst)
              $error("last: expected %0d, got %0d", exp_c.lst, last);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= text_q.size();
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 200000;  // far beyond the slowest clean run
  localparam int TAIL_CYCLES = 30;      // idle tail after the final drain
  localparam int RAND_ITEMS  = 40;      // per idling phase, four phases

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         character;
  logic               last;

  int errors;
  int pending;
  int cycles;
  int idle_pct;   // chance the sender holds off before an item
  int stall_pct;  // chance the receiver drops ready in a cycle

  signed_int_to_decimal_ascii dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last)
  );

  // watches both channels, predicts the text and compares every character
  decimal_text_checker text_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .character (character),
    .last      (last),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("signed_int_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  // receiver: ready drawn fresh every cycle per the current stall rate
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer an item. Called just after the clock rises; returns once the item
  // is taken, leaving valid high so back-to-back items never
  // see a dip.
  task automatic send_number(input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop sending and hold off until every queued character is out.
  // The extra edge lets the checker's count catch up with the last item.
  task automatic drain_text();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random value with a spread of lengths: half full 32-bit words (every
  // bit toggles), half shortened magnitudes of either sign.
  function automatic logic [31:0] pick_number();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(1)) begin
      r = r >> $urandom_range(31, 1);
      if ($urandom_range(1)) r = 32'd0 - r;
    end
    return r;
  endfunction

  logic [31:0] corner_values[] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7FFF_FFFF,              // longest positive: 2147483647
    32'h8000_0000,              // most negative: "-2147483648"
    32'h8000_0001, 32'd1000000000, 32'd999999999, -32'sd1000000000,
    32'd1234567890, -32'sd123456789, 32'd5, -32'sd5, 32'h5555_5555,
    32'hAAAA_AAAA, 32'd100000, -32'sd1
  };

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    value     <= '0;
    out_ready <= 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners at full rate
    foreach (corner_values[i]) send_number(corner_values[i]);

    // let the block go fully idle before the random part
    drain_text();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 64; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 64; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int n = 0; n < RAND_ITEMS; n++) send_number(pick_number());
    end

    drain_text();
    // catch any stray characters after the last expected one
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("signed_int_to_decimal_ascii: match");
    end else begin
      $display("signed_int_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule

>>> signed_int_to_decimal_ascii.f
rtl/core/sida_pkg.sv
rtl/core/sida_dp.sv
rtl/core/sida_ctrl.sv
rtl/core/signed_int_to_decimal_ascii.sv
tb/decimal_text_checker.sv
tb/testbench.sv
